@@ src/zph_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package zph_pkg;

  localparam int unsigned BOARD_CELLS_DEF = 361;
  localparam int unsigned MAX_COUNT       = 5;
  localparam int unsigned COUNT_SLOTS     = 6;

  localparam logic [63:0] GEN_SEED = 64'h1234_5678_9ABC_DEF0;
  localparam logic [63:0] GEN_MUL  = 64'h5851_F42D_4C95_7F2D;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned CELL_W  = 9;
  localparam int unsigned COLOR_W = 2;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned HASH_W  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR        = 3'd0,
    OP_PLACE        = 3'd1,
    OP_CAPTURE      = 3'd2,
    OP_TOGGLE       = 3'd3,
    OP_COUNT_CHANGE = 3'd4,
    OP_ADD_COUNT    = 3'd5
  } op_t;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd2;

  function automatic logic [2:0] clamp_count(input logic [COUNT_W-1:0] c);
    logic [2:0] r;
    if (c > COUNT_W'(MAX_COUNT)) begin
      r = 3'(MAX_COUNT);
    end else begin
      r = c[2:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/zph_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface zph_in_if;
  import zph_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CELL_W-1:0]  cell_index;
  logic [COLOR_W-1:0] stone_color;
  logic [COUNT_W-1:0] old_capture_count;
  logic [COUNT_W-1:0] new_capture_count;

  modport source (
    output valid, operation, cell_index, stone_color, old_capture_count, new_capture_count,
    input  ready
  );
  modport sink (
    input  valid, operation, cell_index, stone_color, old_capture_count, new_capture_count,
    output ready
  );
endinterface

interface zph_out_if;
  import zph_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

`default_nettype wire

@@ src/zph_key_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module zph_key_store
  import zph_pkg::*;
#(
  parameter int unsigned BOARD_CELLS = BOARD_CELLS_DEF,
  parameter int unsigned KEY_TOTAL   = 2 * BOARD_CELLS + 2 * COUNT_SLOTS + 1,
  parameter int unsigned AW          = $clog2(KEY_TOTAL)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr_a,
  input  wire logic [AW-1:0]     rd_addr_b,
  output logic      [HASH_W-1:0] rd_data_a,
  output logic      [HASH_W-1:0] rd_data_b,
  output logic                   keys_ready
);

  typedef enum logic [2:0] {
    FILL_MUL = 3'b001,
    FILL_ADD = 3'b010,
    RUNNING  = 3'b100
  } fill_state_t;

  fill_state_t       state_r, state_nxt;
  logic [63:0]       gen_r;
  logic [63:0]       gen_nxt;
  logic [AW-1:0]     pos_r;
  logic [63:0]       pp_ll_r;
  logic [31:0]       pp_hl_r;
  logic [31:0]       pp_lh_r;
  logic [63:0]       pp_ll_nxt;
  logic [31:0]       pp_hl_nxt;
  logic [31:0]       pp_lh_nxt;
  logic              last_key;
  logic [HASH_W-1:0] key_mem [KEY_TOTAL];

  assign pp_ll_nxt = gen_r[31:0] * GEN_MUL[31:0];
  assign pp_hl_nxt = gen_r[63:32] * GEN_MUL[31:0];
  assign pp_lh_nxt = gen_r[31:0] * GEN_MUL[63:32];
  assign gen_nxt   = pp_ll_r + {pp_hl_r + pp_lh_r, 32'd0} + 64'd1;
  assign last_key  = (pos_r == AW'(KEY_TOTAL - 1));
  assign keys_ready = (state_r == RUNNING);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FILL_MUL: state_nxt = FILL_ADD;
      FILL_ADD: state_nxt = last_key ? RUNNING : FILL_MUL;
      RUNNING:  state_nxt = RUNNING;
      default:  state_nxt = FILL_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL_MUL;
      gen_r   <= GEN_SEED;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FILL_ADD) begin
        gen_r <= gen_nxt;
        if (!last_key) begin
          pos_r <= pos_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FILL_MUL) begin
      pp_ll_r <= pp_ll_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_lh_r <= pp_lh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FILL_ADD) begin
      key_mem[pos_r] <= gen_nxt;
    end
    if (rd_en) begin
      rd_data_a <= key_mem[rd_addr_a];
      rd_data_b <= key_mem[rd_addr_b];
    end
  end

  a_running_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RUNNING |=> state_r == RUNNING)
    else $error("key store left the running state without reset");

  a_fill_complete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RUNNING |-> last_key)
    else $error("key store ready before every key was written");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= AW'(KEY_TOTAL - 1))
    else $error("fill position ran past the last key");

endmodule

`default_nettype wire

@@ src/zobrist_position_hash.sv @@
// An accepted item passes through the read stage and the output register
// before its result is offered. Throughput: one item per cycle while the
// output does not stall; both key reads of an item use the two read ports
// of the key memory in the same cycle. Reset: the hash clears to zero, then
// the generator fills the key memory, each of its 2 * BOARD_CELLS + 13 keys
// in a multiply state and an add state, and no item is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module zobrist_position_hash
  import zph_pkg::*;
#(
  parameter int unsigned BOARD_CELLS = BOARD_CELLS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  zph_in_if.sink    in_ch,
  zph_out_if.source out_ch
);

  localparam int unsigned KEY_TOTAL    = 2 * BOARD_CELLS + 2 * COUNT_SLOTS + 1;
  localparam int unsigned AW           = $clog2(KEY_TOTAL);
  localparam int unsigned WW           = AW + CELL_W + 1;
  localparam int unsigned CAPTURE_BASE = 2 * BOARD_CELLS;
  localparam int unsigned SIDE_SLOT    = CAPTURE_BASE + 2 * COUNT_SLOTS;

  typedef struct packed {
    logic clr;
    logic use_a;
    logic use_b;
  } s1_ctl_t;

  logic              keys_ready;
  logic              advance;
  logic              accept;
  logic [WW-1:0]     stone_wide;
  logic              stone_ok;
  logic [AW-1:0]     stone_addr;
  logic [AW-1:0]     side_base;
  logic [AW-1:0]     old_count_addr;
  logic [AW-1:0]     new_count_addr;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;
  s1_ctl_t           ctl_nxt;
  s1_ctl_t           s1_ctl_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] rd_data_a;
  logic [HASH_W-1:0] rd_data_b;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = keys_ready && advance;
  assign accept       = in_ch.valid && in_ch.ready;

  assign stone_wide = (WW'(in_ch.cell_index) << 1) | WW'(in_ch.stone_color == COLOR_WHITE);
  assign stone_addr = stone_wide[AW-1:0];
  assign stone_ok   = (WW'(in_ch.cell_index) < WW'(BOARD_CELLS)) &&
                      ((in_ch.stone_color == COLOR_BLACK) ||
                       (in_ch.stone_color == COLOR_WHITE));
  assign side_base  = AW'(CAPTURE_BASE) +
                      ((in_ch.stone_color == COLOR_BLACK) ? AW'(0) : AW'(COUNT_SLOTS));
  assign old_count_addr = side_base + AW'(clamp_count(in_ch.old_capture_count));
  assign new_count_addr = side_base + AW'(clamp_count(in_ch.new_capture_count));

  always_comb begin
    ctl_nxt = '0;
    addr_a  = stone_addr;
    addr_b  = AW'(SIDE_SLOT);
    case (in_ch.operation)
      OP_CLEAR: begin
        ctl_nxt.clr = 1'b1;
      end
      OP_PLACE: begin
        ctl_nxt.use_a = stone_ok;
        ctl_nxt.use_b = 1'b1;
      end
      OP_CAPTURE: begin
        ctl_nxt.use_a = stone_ok;
      end
      OP_TOGGLE: begin
        ctl_nxt.use_b = 1'b1;
      end
      OP_COUNT_CHANGE: begin
        ctl_nxt.use_a = 1'b1;
        ctl_nxt.use_b = 1'b1;
        addr_a        = old_count_addr;
        addr_b        = new_count_addr;
      end
      OP_ADD_COUNT: begin
        ctl_nxt.use_a = 1'b1;
        addr_a        = new_count_addr;
      end
      default: begin
        ctl_nxt = '0;
      end
    endcase
  end

  zph_key_store #(
    .BOARD_CELLS (BOARD_CELLS),
    .KEY_TOTAL   (KEY_TOTAL),
    .AW          (AW)
  ) u_key_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr_a  (addr_a),
    .rd_addr_b  (addr_b),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .keys_ready (keys_ready)
  );

  assign hash_nxt = s1_ctl_r.clr ? '0 :
                    hash_r ^ (s1_ctl_r.use_a ? rd_data_a : '0)
                           ^ (s1_ctl_r.use_b ? rd_data_b : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hash_r      <= '0;
    end else if (advance) begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        hash_r <= hash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = hash_r;

  a_no_accept_filling: assert property (@(posedge clk) disable iff (!rst_n)
    !keys_ready |-> !in_ch.ready)
    else $error("item taken while the key memory is still filling");

  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item did not reach the read stage");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance && s1_ctl_r.clr |=> hash_r == '0 && out_valid_r)
    else $error("clear item did not give a zero hash");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(hash_r))
    else $error("read stage item lost while the output stalled");

endmodule

`default_nettype wire

@@ sim/tb_zobrist_position_hash.sv @@
`timescale 1ns / 1ps

module tb_zobrist_position_hash;
  import zph_pkg::*;

  localparam int unsigned KEY_COUNT    = 2 * BOARD_CELLS_DEF + 2 * COUNT_SLOTS + 1;
  localparam int unsigned CAPTURE_BASE = 2 * BOARD_CELLS_DEF;
  localparam int unsigned SIDE_SLOT    = CAPTURE_BASE + 2 * COUNT_SLOTS;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned ROW_COUNT    = 24;

  localparam logic [OP_W-1:0]    OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0]    OP_SPARE_HI = 3'd7;
  localparam logic [COLOR_W-1:0] COLOR_EMPTY = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CELL_W-1:0]  site;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] old_cnt;
    logic [COUNT_W-1:0] new_cnt;
  } hash_update_t;

  typedef struct packed {
    hash_update_t      upd;
    logic              fixed;
    logic [HASH_W-1:0] fixed_hash;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  zph_in_if  in_ch ();
  zph_out_if out_ch ();

  zobrist_position_hash dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [HASH_W-1:0] key_table [KEY_COUNT];
  logic [HASH_W-1:0] position_hash;
  logic [HASH_W-1:0] expected_hashes [$];
  logic [HASH_W-1:0] oldest_hash;
  directed_row_t     directed_rows [ROW_COUNT];

  int unsigned cycle_count    = 0;
  int unsigned failures       = 0;
  int unsigned hashes_checked = 0;
  int unsigned accepted_items = 0;
  int unsigned burst_left     = 0;
  int unsigned boards_built   = 0;
  int unsigned op_seen [8];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [HASH_W-1:0] stone_key_of(input logic [CELL_W-1:0] site,
                                                     input logic [COLOR_W-1:0] color);
    logic [HASH_W-1:0] k;
    k = '0;
    if (site < BOARD_CELLS_DEF) begin
      if (color == COLOR_BLACK) begin
        k = key_table[2 * site];
      end else if (color == COLOR_WHITE) begin
        k = key_table[2 * site + 1];
      end
    end
    return k;
  endfunction

  function automatic logic [HASH_W-1:0] tally_key_of(input logic [COLOR_W-1:0] color,
                                                     input logic [COUNT_W-1:0] tally);
    int unsigned side;
    int unsigned slot;
    side = (color == COLOR_BLACK) ? 0 : 1;
    slot = (tally > MAX_COUNT) ? MAX_COUNT : tally;
    return key_table[CAPTURE_BASE + side * COUNT_SLOTS + slot];
  endfunction

  function automatic logic [HASH_W-1:0] advance_position_hash(input hash_update_t u);
    case (u.op)
      OP_CLEAR: begin
        position_hash = '0;
      end
      OP_PLACE: begin
        position_hash ^= stone_key_of(u.site, u.color) ^ key_table[SIDE_SLOT];
      end
      OP_CAPTURE: begin
        position_hash ^= stone_key_of(u.site, u.color);
      end
      OP_TOGGLE: begin
        position_hash ^= key_table[SIDE_SLOT];
      end
      OP_COUNT_CHANGE: begin
        position_hash ^= tally_key_of(u.color, u.old_cnt) ^ tally_key_of(u.color, u.new_cnt);
      end
      OP_ADD_COUNT: begin
        position_hash ^= tally_key_of(u.color, u.new_cnt);
      end
      default: begin
      end
    endcase
    return position_hash;
  endfunction

  function automatic hash_update_t random_update();
    hash_update_t u;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      u.op = OP_CLEAR;
    end else if (pick < 34) begin
      u.op = OP_PLACE;
    end else if (pick < 49) begin
      u.op = OP_CAPTURE;
    end else if (pick < 59) begin
      u.op = OP_TOGGLE;
    end else if (pick < 74) begin
      u.op = OP_COUNT_CHANGE;
    end else if (pick < 89) begin
      u.op = OP_ADD_COUNT;
    end else begin
      u.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    end
    u.site    = ($urandom_range(0, 9) != 0) ? CELL_W'($urandom_range(0, BOARD_CELLS_DEF - 1))
                                            : CELL_W'($urandom_range(0, 511));
    u.color   = ($urandom_range(0, 4) != 0) ? COLOR_W'($urandom_range(1, 2))
                                            : COLOR_W'($urandom_range(0, 3));
    u.old_cnt = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(0, 6))
                                           : COUNT_W'($urandom_range(0, 255));
    u.new_cnt = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(0, 6))
                                           : COUNT_W'($urandom_range(0, 255));
    return u;
  endfunction

  task automatic offer_update(input hash_update_t u, input logic fixed,
                              input logic [HASH_W-1:0] fixed_hash);
    int unsigned idle_gap;
    logic [HASH_W-1:0] predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle_gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (idle_gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.operation         <= u.op;
    in_ch.cell_index        <= u.site;
    in_ch.stone_color       <= u.color;
    in_ch.old_capture_count <= u.old_cnt;
    in_ch.new_capture_count <= u.new_cnt;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = advance_position_hash(u);
    expected_hashes.push_back(fixed ? fixed_hash : predicted);
    accepted_items++;
    op_seen[u.op]++;
    @(negedge clk);
  endtask

  task automatic build_board();
    hash_update_t u;
    int unsigned stones;
    int unsigned moves;
    logic [COUNT_W-1:0] black_tally;
    logic [COUNT_W-1:0] white_tally;
    boards_built++;
    u = '0;
    u.op = OP_CLEAR;
    offer_update(u, 1'b0, '0);
    stones = $urandom_range(1, 15);
    for (int s = 0; s < stones; s++) begin
      u = random_update();
      u.op    = OP_CAPTURE;
      u.site  = CELL_W'($urandom_range(0, BOARD_CELLS_DEF - 1));
      u.color = COLOR_W'($urandom_range(1, 2));
      offer_update(u, 1'b0, '0);
    end
    if ($urandom_range(0, 1) == 0) begin
      u.op = OP_TOGGLE;
      offer_update(u, 1'b0, '0);
    end
    black_tally = COUNT_W'($urandom_range(0, 5));
    white_tally = COUNT_W'($urandom_range(0, 5));
    u = random_update();
    u.op      = OP_ADD_COUNT;
    u.color   = COLOR_BLACK;
    u.new_cnt = black_tally;
    offer_update(u, 1'b0, '0);
    u.color   = COLOR_WHITE;
    u.new_cnt = white_tally;
    offer_update(u, 1'b0, '0);
    moves = $urandom_range(1, 6);
    for (int m = 0; m < moves; m++) begin
      u = random_update();
      u.op    = OP_PLACE;
      u.site  = CELL_W'($urandom_range(0, BOARD_CELLS_DEF - 1));
      u.color = COLOR_W'($urandom_range(1, 2));
      offer_update(u, 1'b0, '0);
      if ($urandom_range(0, 2) == 0) begin
        u.op = OP_CAPTURE;
        u.color = (u.color == COLOR_BLACK) ? COLOR_WHITE : COLOR_BLACK;
        offer_update(u, 1'b0, '0);
        u.op = OP_COUNT_CHANGE;
        u.color = (u.color == COLOR_BLACK) ? COLOR_WHITE : COLOR_BLACK;
        if (u.color == COLOR_BLACK) begin
          u.old_cnt   = black_tally;
          black_tally = black_tally + COUNT_W'(1);
          u.new_cnt   = black_tally;
        end else begin
          u.old_cnt   = white_tally;
          white_tally = white_tally + COUNT_W'(1);
          u.new_cnt   = white_tally;
        end
        offer_update(u, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_hashes.size() == 0) begin
        $error("hash_value: expected nothing, actual %h", out_ch.hash_value);
        failures++;
      end else begin
        oldest_hash = expected_hashes.pop_front();
        hashes_checked++;
        if (out_ch.hash_value !== oldest_hash) begin
          $error("hash_value: expected %h, actual %h", oldest_hash, out_ch.hash_value);
          failures++;
        end
      end
    end
  end

  // The receiver cycles through its own stall patterns, and once holds off
  // long enough for the block to fill up and refuse further items.
  initial begin
    int unsigned drain_tick;
    logic held_off;
    drain_tick = 0;
    held_off = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      drain_tick++;
      if (!held_off && accepted_items >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        case ((drain_tick / 97) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 2) == 0);
          default: out_ch.ready <= ((drain_tick % 8) < 5);
        endcase
      end
    end
  end

  initial begin
    logic [HASH_W-1:0] lcg;
    hash_update_t u;
    lcg = GEN_SEED;
    for (int k = 0; k < KEY_COUNT; k++) begin
      lcg = lcg * GEN_MUL + 64'd1;
      key_table[k] = lcg;
    end
    position_hash = '0;
    foreach (op_seen[i]) op_seen[i] = 0;

    directed_rows = '{
      '{'{OP_CLEAR,        9'd0,   COLOR_EMPTY, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_SPARE_LO,     9'd511, COLOR_SPARE, 8'd255, 8'd255}, 1'b1, 64'd0},
      '{'{OP_SPARE_HI,     9'd0,   COLOR_BLACK, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_CAPTURE,      9'd0,   COLOR_EMPTY, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_CAPTURE,      9'd360, COLOR_SPARE, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_CAPTURE,      9'd361, COLOR_BLACK, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_CAPTURE,      9'd511, COLOR_WHITE, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_PLACE,        9'd0,   COLOR_BLACK, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_PLACE,        9'd360, COLOR_WHITE, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_PLACE,        9'd511, COLOR_BLACK, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_PLACE,        9'd5,   COLOR_EMPTY, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_CAPTURE,      9'd0,   COLOR_BLACK, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_TOGGLE,       9'd0,   COLOR_EMPTY, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_COUNT_CHANGE, 9'd0,   COLOR_BLACK, 8'd0,   8'd5},   1'b0, 64'd0},
      '{'{OP_COUNT_CHANGE, 9'd0,   COLOR_WHITE, 8'd255, 8'd6},   1'b0, 64'd0},
      '{'{OP_COUNT_CHANGE, 9'd0,   COLOR_SPARE, 8'd3,   8'd200}, 1'b0, 64'd0},
      '{'{OP_COUNT_CHANGE, 9'd0,   COLOR_EMPTY, 8'd128, 8'd0},   1'b0, 64'd0},
      '{'{OP_ADD_COUNT,    9'd0,   COLOR_BLACK, 8'd0,   8'd255}, 1'b0, 64'd0},
      '{'{OP_ADD_COUNT,    9'd0,   COLOR_EMPTY, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_SPARE_LO,     9'd100, COLOR_WHITE, 8'd7,   8'd9},   1'b0, 64'd0},
      '{'{OP_CLEAR,        9'd511, COLOR_SPARE, 8'd255, 8'd255}, 1'b1, 64'd0},
      '{'{OP_TOGGLE,       9'd0,   COLOR_EMPTY, 8'd0,   8'd0},   1'b0, 64'd0},
      '{'{OP_TOGGLE,       9'd0,   COLOR_EMPTY, 8'd0,   8'd0},   1'b1, 64'd0},
      '{'{OP_PLACE,        9'd256, COLOR_BLACK, 8'd255, 8'd255}, 1'b0, 64'd0}
    };

    rst_n = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.operation         = OP_CLEAR;
    in_ch.cell_index        = '0;
    in_ch.stone_color       = COLOR_EMPTY;
    in_ch.old_capture_count = '0;
    in_ch.new_capture_count = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      offer_update(directed_rows[r].upd, directed_rows[r].fixed, directed_rows[r].fixed_hash);
    end

    while (accepted_items < ROW_COUNT + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        build_board();
      end else begin
        repeat ($urandom_range(1, 10)) begin
          u = random_update();
          offer_update(u, 1'b0, '0);
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_hashes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_hashes.size() != 0) begin
      $error("hash_value: %0d expected results never arrived", expected_hashes.size());
      failures++;
    end

    $display("Run summary: %0d items (clear %0d, place %0d, capture %0d, toggle %0d,",
             accepted_items, op_seen[OP_CLEAR], op_seen[OP_PLACE], op_seen[OP_CAPTURE],
             op_seen[OP_TOGGLE]);
    $display("  count change %0d, add count %0d, unused codes %0d), %0d boards, %0d checked.",
             op_seen[OP_COUNT_CHANGE], op_seen[OP_ADD_COUNT],
             op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI], boards_built, hashes_checked);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
